/* design/vstp_pkg.sv */
// Package for the signature type parser: word structs, level encoding, classifier.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vstp_pkg;

	typedef struct packed {
		logic [7:0] type_char;
		logic       end_of_signature;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  align_log2;
		logic [15:0] fixed_bytes;
		logic [15:0] bound_child_bytes;
		logic [8:0]  depth_used;
		logic [12:0] type_length;
		logic [11:0] type_offset;
		logic        final_result;
	} out_word_t;

	typedef enum logic [1:0] {
		K_TUPLE = 2'd0,
		K_PAIR0 = 2'd1,
		K_PAIR1 = 2'd2,
		K_BOUND = 2'd3
	} kind_t;

	typedef struct packed {
		logic [2:0] pad;
		logic [1:0] align;
		kind_t      kind;
	} level_t;

	typedef enum logic [2:0] {
		C_INVALID = 3'd0,
		C_LEAF    = 3'd1,
		C_OPEN    = 3'd2,
		C_TCLOSE  = 3'd3,
		C_PCLOSE  = 3'd4
	} cls_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_MALFORM  = 2'd1,
		ST_DEEP     = 2'd2,
		ST_TOO_LONG = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EXEC = 2'd1,
		S_POP  = 2'd2
	} fsm_t;

	typedef struct packed {
		cls_t       cls;
		logic [1:0] align;
		logic       fixed;
		logic       basic;
	} char_info_t;

	function automatic char_info_t classify(input logic [7:0] c);
		char_info_t r;
		r = '{cls: C_LEAF, align: 2'd0, fixed: 1'b1, basic: 1'b1};
		case (c)
			"b", "y": ;
			"n", "q": r.align = 2'd1;
			"i", "u", "h": r.align = 2'd2;
			"x", "t", "d": r.align = 2'd3;
			"s", "o", "g": r.fixed = 1'b0;
			"v": begin
				r.align = 2'd3; r.fixed = 1'b0; r.basic = 1'b0;
			end
			"m", "a", "(", "{": r.cls = C_OPEN;
			")": r.cls = C_TCLOSE;
			"}": r.cls = C_PCLOSE;
			default: r.cls = C_INVALID;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* design/vstp_cell.sv */
// One cell of the level stack chain: holds one saved level, shifts with neighbors.
// Depends on vstp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vstp_cell
	import vstp_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   push,
	input  wire logic   pop,
	input  wire level_t from_above,
	input  wire level_t from_below,
	output level_t      level
);
	level_t level_q;

	// push: take the level from the cell above (toward the top); pop: take from below
	always_ff @(posedge clk) begin
		if (push) begin
			level_q <= from_above;
		end else if (pop) begin
			level_q <= from_below;
		end
	end

	assign level = level_q;
endmodule
`default_nettype wire

/* design/vstp_stack.sv */
// Level stack as a chain of shift cells; cell 0 holds the most recent level.
// Depends on vstp_pkg and vstp_cell.
`timescale 1ns / 1ps
`default_nettype none
module vstp_stack
	import vstp_pkg::*;
#(
	parameter int DEPTH = 256
) (
	input  wire logic   clk,
	input  wire logic   push,
	input  wire logic   pop,
	input  wire level_t push_level,
	output level_t      top_level
);
	level_t chain [DEPTH+1];

	assign chain[DEPTH] = '0;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		level_t above;
		if (g == 0) begin : g_head
			assign above = push_level;
		end else begin : g_body
			assign above = chain[g-1];
		end
		vstp_cell u_cell (
			.clk       (clk),
			.push      (push),
			.pop       (pop),
			.from_above(above),
			.from_below(chain[g+1]),
			.level     (chain[g])
		);
	end

	assign top_level = chain[0];
endmodule
`default_nettype wire

/* design/variant_signature_type_parser_core.sv */
// Top level of the signature type parser: control sequencer, state and result register.
// Depends on vstp_pkg and vstp_stack.
//
// Usage: signature characters arrive one word per handshake on the in channel
// (type_char, end_of_signature). For each complete top-level type, and for
// each error, one result word leaves on the out channel.
// Sequence: each character is accepted, then executed, then one pop state runs for
// each bound container ('a' or 'm') that it closes, one per cycle, through the cell
// chain of the level stack; the next character is accepted only after that.
// A result appears in the output register the cycle after execution ends.
// Stall: the output register holds its word until taken; the next character
// is accepted meanwhile, but its execution waits while the register is
// still full.
// Reset: arst_n clears all control and parse state; the level stack cells
// carry no reset since only pushed entries are read.
// After an error the remaining characters of the signature are dropped.
`timescale 1ns / 1ps
`default_nettype none
module variant_signature_type_parser_core
	import vstp_pkg::*;
#(
	parameter int MAX_DEPTH = 256,
	parameter int MAX_CHARS = 4096
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_word_t in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_word_t     out_data
);
	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int PW = $clog2(MAX_CHARS + 1);

	fsm_t fsm_q, fsm_d;
	in_word_t word_q;
	level_t cur_q, cur_d;
	logic [16:0] size_q, size_d;
	logic [DW-1:0] depth_q, depth_d, maxd_q, maxd_d;
	logic fixed_q, fixed_d, pairc_q, pairc_d, disc_q, disc_d;
	logic [7:0] prev_q, prev_d;
	logic [PW-1:0] pos_q, pos_d, begin_q, begin_d;
	logic [16:0] bound_q, bound_d;
	logic eos_q, eos_d;
	logic ov_q, ov_d;
	out_word_t od_q, od_d;
	logic push, pop;
	level_t push_lv, top_lv;
	logic go_pop;

	vstp_stack #(.DEPTH(MAX_DEPTH)) u_stack (
		.clk       (clk),
		.push      (push),
		.pop       (pop),
		.push_level(push_lv),
		.top_level (top_lv)
	);

	assign in_ready  = (fsm_q == S_IDLE);
	assign out_valid = ov_q;
	assign out_data  = od_q;

	always_comb begin
		fsm_d = fsm_q;
		unique case (fsm_q)
			S_IDLE: if (in_valid) fsm_d = S_EXEC;
			S_EXEC: if (!ov_q || out_ready) fsm_d = S_IDLE;
			S_POP: if (!(top_lv.kind == K_BOUND && depth_q > 1)) fsm_d = S_IDLE;
			default: fsm_d = S_IDLE;
		endcase
		if (fsm_q == S_EXEC && (!ov_q || out_ready) && go_pop) fsm_d = S_POP;
	end

	// datapath
	char_info_t ci;
	logic [16:0] rs, t8, sub;
	logic [3:0] m;
	logic leaf, close;
	status_t err;
	level_t lv;

	function automatic logic [15:0] sat(input logic [16:0] v);
		return v[16] ? 16'hFFFF : v[15:0];
	endfunction

	always_comb begin
		ci = classify(word_q.type_char);
		cur_d = cur_q; size_d = size_q; depth_d = depth_q; maxd_d = maxd_q;
		fixed_d = fixed_q; pairc_d = pairc_q; disc_d = disc_q; prev_d = prev_q;
		pos_d = pos_q; begin_d = begin_q; bound_d = bound_q; eos_d = eos_q;
		ov_d = ov_q && !out_ready; od_d = od_q;
		push = 1'b0; pop = 1'b0; push_lv = cur_q; go_pop = 1'b0;
		err = ST_OK; leaf = 1'b0; close = 1'b0; lv = cur_q; rs = size_q;
		t8 = '0; sub = '0; m = '0;
		if (fsm_q == S_IDLE && in_valid) begin
			eos_d = in_data.end_of_signature;
		end
		if (fsm_q == S_EXEC && (!ov_q || out_ready)) begin
			if (disc_q) begin
				if (word_q.end_of_signature) begin
					disc_d = 1'b0; pos_d = '0; begin_d = '0;
					cur_d = '{pad: 3'd0, align: 2'd0, kind: K_TUPLE};
					size_d = '0; depth_d = '0; maxd_d = '0; fixed_d = 1'b1; pairc_d = 1'b0;
				end
			end else begin
				if ({{(17-PW){1'b0}}, pos_q} >= 17'(MAX_CHARS)) begin
					err = ST_TOO_LONG;
				end else begin
					unique case (ci.cls)
						C_OPEN: begin
							if ({{(17-DW){1'b0}}, depth_q} >= 17'(MAX_DEPTH)) err = ST_DEEP;
							else if (pairc_q || cur_q.kind == K_PAIR0) err = ST_MALFORM;
							else begin
								push = 1'b1;
								depth_d = depth_q + 1'b1;
								if (depth_d > maxd_q) maxd_d = depth_d;
								t8 = (size_q + 17'd7) & ~17'd7;
								cur_d.kind = (word_q.type_char == "(") ? K_TUPLE :
									(word_q.type_char == "{") ? K_PAIR0 : K_BOUND;
								cur_d.align = 2'd0;
								cur_d.pad = 3'(t8 - size_q);
								size_d = t8;
							end
						end
						C_TCLOSE: begin
							if (depth_q == '0 || cur_q.kind != K_TUPLE) err = ST_MALFORM;
							else begin
								if (prev_q == "(") rs = size_q + 17'd1;
								close = 1'b1;
							end
						end
						C_PCLOSE: begin
							if (!pairc_q) err = ST_MALFORM;
							else close = 1'b1;
						end
						C_LEAF: begin
							if (pairc_q || (cur_q.kind == K_PAIR0 && !ci.basic)) err = ST_MALFORM;
							else begin
								fixed_d = fixed_q & ci.fixed;
								lv.align = (ci.align > cur_q.align) ? ci.align : cur_q.align;
								if (fixed_d) begin
									m = (4'd1 << ci.align) - 4'd1;
									rs = ((size_q + {13'd0, m}) & ~{13'd0, m})
										+ {13'd0, m} + 17'd1;
								end
								leaf = 1'b1;
							end
						end
						default: err = ST_MALFORM;
					endcase
					if (close) begin
						if (fixed_q) begin
							m = (4'd1 << cur_q.align) - 4'd1;
							sub = {14'd0, cur_q.pad & ~m[2:0]};
							rs = (rs >= sub) ? rs - sub : '0;
							rs = (rs + {13'd0, m}) & ~{13'd0, m};
						end
						pop = 1'b1;
						depth_d = depth_q - 1'b1;
						lv = top_lv;
						lv.align = (cur_q.align > top_lv.align) ? cur_q.align : top_lv.align;
						pairc_d = 1'b0;
						leaf = 1'b1;
					end
					prev_d = word_q.type_char;
					if (leaf) begin
						size_d = rs; cur_d = lv;
						if (lv.kind == K_BOUND && depth_d != '0) begin
							go_pop = 1'b1;
						end
					end
				end
				if (err != ST_OK) begin
					pop = 1'b0; push = 1'b0; go_pop = 1'b0;
				end
			end
		end
		// one bound pop per cycle
		if (fsm_q == S_POP) begin
			bound_d = fixed_q ? size_q : '0;
			fixed_d = 1'b0;
			pop = 1'b1;
			depth_d = depth_q - 1'b1;
			cur_d = top_lv;
			cur_d.align = (cur_q.align > top_lv.align) ? cur_q.align : top_lv.align;
			if (!(top_lv.kind == K_BOUND && depth_q > 1)) leaf = 1'b1;
			lv = cur_d;
		end
		// leaf completion, not when further pops follow
		if (leaf && !go_pop && err == ST_OK && !disc_q) begin
			if (lv.kind == K_PAIR0) cur_d.kind = K_PAIR1;
			else if (lv.kind == K_PAIR1) pairc_d = 1'b1;
			if (depth_d == '0) begin
				ov_d = 1'b1;
				od_d.status = ST_OK;
				od_d.align_log2 = cur_d.align;
				od_d.fixed_bytes = fixed_d ? sat(size_d) : 16'd0;
				od_d.bound_child_bytes = sat(bound_d);
				od_d.depth_used = 9'(maxd_d);
				od_d.type_length = 13'(pos_q + 1'b1 - begin_q);
				od_d.type_offset = 12'(begin_q);
				od_d.final_result = eos_q;
				cur_d = '{pad: 3'd0, align: 2'd0, kind: K_TUPLE};
				size_d = '0; depth_d = '0; maxd_d = '0; fixed_d = 1'b1; pairc_d = 1'b0;
				bound_d = '0;
				if (eos_q) begin
					pos_d = '0; begin_d = '0;
				end else begin
					pos_d = pos_q + 1'b1; begin_d = pos_q + 1'b1;
				end
			end else if (eos_q) begin
				err = ST_MALFORM;
			end else begin
				pos_d = pos_q + 1'b1;
				bound_d = '0;
			end
		end else if (fsm_q == S_EXEC && (!ov_q || out_ready) && !disc_q && !leaf
				&& err == ST_OK) begin
			if (eos_q) err = ST_MALFORM;
			else pos_d = pos_q + 1'b1;
		end
		if (err != ST_OK) begin
			ov_d = 1'b1;
			od_d = '0;
			od_d.status = err;
			od_d.final_result = 1'b1;
			cur_d = '{pad: 3'd0, align: 2'd0, kind: K_TUPLE};
			size_d = '0; depth_d = '0; maxd_d = '0; fixed_d = 1'b1; pairc_d = 1'b0;
			bound_d = '0;
			if (eos_q) begin
				pos_d = '0; begin_d = '0;
			end else begin
				disc_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q <= S_IDLE;
			cur_q <= '{pad: 3'd0, align: 2'd0, kind: K_TUPLE};
			size_q <= '0; depth_q <= '0; maxd_q <= '0;
			fixed_q <= 1'b1; pairc_q <= 1'b0; disc_q <= 1'b0;
			prev_q <= '0; pos_q <= '0; begin_q <= '0; bound_q <= '0;
			eos_q <= 1'b0; ov_q <= 1'b0;
		end else begin
			fsm_q <= fsm_d;
			cur_q <= cur_d; size_q <= size_d; depth_q <= depth_d; maxd_q <= maxd_d;
			fixed_q <= fixed_d; pairc_q <= pairc_d; disc_q <= disc_d;
			prev_q <= prev_d; pos_q <= pos_d; begin_q <= begin_d; bound_q <= bound_d;
			eos_q <= eos_d; ov_q <= ov_d;
		end
	end

	// hold the accepted word and the result word
	always_ff @(posedge clk) begin
		if (fsm_q == S_IDLE && in_valid) word_q <= in_data;
		od_q <= od_d;
	end
endmodule
`default_nettype wire

/* verif/variant_signature_type_parser_core_test.sv */
// Self-checking testbench for variant_signature_type_parser_core: feeds signature words,
// predicts each result with an in-bench parser model and checks every result word.
// Depends on vstp_pkg and the design files.
`timescale 1ns / 1ps
`default_nettype none
module variant_signature_type_parser_core_test
	import vstp_pkg::*;
();

	localparam int DEPTH_LIMIT = 256;
	localparam int CHAR_LIMIT  = 4096;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SW          = $clog2(DEPTH_LIMIT);

	// Signature parser prediction: mirrors the parse state, queues expected results.
	class sig_parse_scoreboard;
		level_t      stk [DEPTH_LIMIT];
		level_t      cur;
		int unsigned run_sz, depth, max_dep, pos, begin_pos;
		bit          fixed_so_far, pair_done, dropping;
		logic [7:0]  prev;
		out_word_t   want_q [$];
		int          errors;

		function new();
			clear_type();
			prev = '0; pos = 0; begin_pos = 0; dropping = 0; errors = 0;
		endfunction

		function void clear_type();
			cur = '{pad: 3'd0, align: 2'd0, kind: K_TUPLE};
			run_sz = 0; depth = 0; max_dep = 0; fixed_so_far = 1; pair_done = 0;
		endfunction

		function cls_t char_class(input logic [7:0] c, output int unsigned al,
				output bit fx, output bit bs);
			al = 0; fx = 1; bs = 1;
			case (c)
				"b", "y": return C_LEAF;
				"n", "q": begin al = 1; return C_LEAF; end
				"i", "u", "h": begin al = 2; return C_LEAF; end
				"x", "t", "d": begin al = 3; return C_LEAF; end
				"s", "o", "g": begin fx = 0; return C_LEAF; end
				"v": begin al = 3; fx = 0; bs = 0; return C_LEAF; end
				"m", "a", "(", "{": return C_OPEN;
				")": return C_TCLOSE;
				"}": return C_PCLOSE;
				default: return C_INVALID;
			endcase
		endfunction

		function void pop_level();
			level_t sv;
			if (depth == 0) return;
			depth--;
			sv = stk[depth[SW-1:0]];
			if (cur.align > sv.align) sv.align = cur.align;
			cur = sv;
		endfunction

		function void note_char(input in_word_t w);
			logic [7:0]  c;
			bit          eos, fx, bs, leaf, done, close;
			status_t     err;
			cls_t        cl;
			int unsigned al, m, t, sub, bnd;
			out_word_t   r;
			c = w.type_char; eos = w.end_of_signature;
			err = ST_OK; leaf = 0; done = 0; close = 0; bnd = 0;
			// drop the rest of a failed signature
			if (dropping) begin
				if (eos) begin
					dropping = 0; clear_type(); pos = 0; begin_pos = 0;
				end
				return;
			end
			if (pos >= CHAR_LIMIT) begin
				err = ST_TOO_LONG;
			end else begin
				cl = char_class(c, al, fx, bs);
				case (cl)
					C_OPEN: begin
						if (depth >= DEPTH_LIMIT) err = ST_DEEP;
						else if (pair_done || cur.kind == K_PAIR0) err = ST_MALFORM;
						else begin
							stk[depth[SW-1:0]] = cur;
							depth++;
							if (depth > max_dep) max_dep = depth;
							t = (run_sz + 7) & ~32'd7;
							cur.kind = (c == "(") ? K_TUPLE : (c == "{") ? K_PAIR0 : K_BOUND;
							cur.align = 2'd0;
							cur.pad = 3'(t - run_sz);
							run_sz = t;
						end
					end
					C_TCLOSE: begin
						if (depth == 0 || cur.kind != K_TUPLE) err = ST_MALFORM;
						else begin
							if (prev == "(") run_sz += 1;
							close = 1;
						end
					end
					C_PCLOSE: begin
						if (!pair_done) err = ST_MALFORM;
						else close = 1;
					end
					C_LEAF: begin
						if (pair_done || (cur.kind == K_PAIR0 && !bs)) err = ST_MALFORM;
						else begin
							if (!fx) fixed_so_far = 0;
							if (al > cur.align) cur.align = 2'(al);
							if (fixed_so_far) begin
								m = (1 << al) - 1;
								run_sz = ((run_sz + m) & ~m) + (1 << al);
							end
							leaf = 1;
						end
					end
					default: err = ST_MALFORM;
				endcase
				if (close) begin
					if (fixed_so_far) begin
						m = (1 << cur.align) - 1;
						sub = cur.pad & ~m;
						run_sz = (run_sz >= sub) ? run_sz - sub : 0;
						run_sz = (run_sz + m) & ~m;
					end
					pop_level();
					pair_done = 0;
					leaf = 1;
				end
				if (leaf) begin
					// a finished element closes every bound container around it
					while (cur.kind == K_BOUND && depth > 0) begin
						bnd = fixed_so_far ? run_sz : 0;
						fixed_so_far = 0;
						pop_level();
					end
					if (cur.kind == K_PAIR0) cur.kind = K_PAIR1;
					else if (cur.kind == K_PAIR1) pair_done = 1;
					done = (depth == 0);
				end
				prev = c;
				if (!done && err == ST_OK && eos) err = ST_MALFORM;
			end
			if (err != ST_OK) begin
				r = '0;
				r.status = err;
				r.final_result = 1'b1;
				want_q.push_back(r);
				if (eos) begin
					clear_type(); pos = 0; begin_pos = 0;
				end else dropping = 1;
				return;
			end
			if (!done) begin
				pos++;
				return;
			end
			r.status = ST_OK;
			r.align_log2 = cur.align;
			r.fixed_bytes = !fixed_so_far ? 16'd0 : (run_sz > 65535) ? 16'hFFFF : 16'(run_sz);
			r.bound_child_bytes = (bnd > 65535) ? 16'hFFFF : 16'(bnd);
			r.depth_used = 9'(max_dep);
			r.type_length = 13'(pos + 1 - begin_pos);
			r.type_offset = 12'(begin_pos);
			r.final_result = eos;
			want_q.push_back(r);
			clear_type();
			if (eos) begin
				pos = 0; begin_pos = 0;
			end else begin
				pos++; begin_pos = pos;
			end
		endfunction

		function void check_result(input out_word_t got);
			out_word_t e;
			if (want_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result word, expected none, actual %h", $time, got);
				return;
			end
			e = want_q.pop_front();
			if (got !== e) begin
				errors++;
				$display("%0t: result mismatch, expected %h, actual %h", $time, e, got);
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_data;

	sig_parse_scoreboard sb;
	int  gap_pct, stall_pct, hold_left, cycles, words_sent;
	bit  hold_req;

	variant_signature_type_parser_core #(
		.MAX_DEPTH(DEPTH_LIMIT),
		.MAX_CHARS(CHAR_LIMIT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Result side: stall at random, or hold off for a long stretch on request.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			out_ready = 0;
			hold_left--;
		end else
			out_ready = ($urandom_range(99) >= stall_pct);
	end

	// Check every result word taken at the rising edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
	end

	// Offer one word, idling first at random; return at the falling edge after acceptance.
	task automatic send_char(input logic [7:0] c, input bit e);
		while ($urandom_range(99) < gap_pct) begin
			in_valid = 0;
			@(negedge clk);
		end
		in_valid = 1;
		in_data = '{type_char: c, end_of_signature: e};
		do @(posedge clk); while (!in_ready);
		sb.note_char(in_data);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_seq(input logic [7:0] q [$]);
		foreach (q[i]) send_char(q[i], i == q.size() - 1);
	endtask

	task automatic send_text(input string s);
		logic [7:0] q [$];
		for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
		send_seq(q);
	endtask

	// Pause the sender until every expected result has arrived.
	task automatic drain();
		in_valid = 0;
		while (sb.want_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_basic();
		string b;
		b = "bynqiuxthdsog";
		return b[$urandom_range(b.len() - 1)];
	endfunction

	// Build one well-formed complete type with random content.
	function automatic void build_type(ref logic [7:0] q [$], input int lvl);
		int pick, n;
		pick = (lvl >= 5) ? 0 : $urandom_range(0, 9);
		case (pick)
			5: begin q.push_back("a"); build_type(q, lvl + 1); end
			6: begin q.push_back("m"); build_type(q, lvl + 1); end
			7: begin
				q.push_back("(");
				n = $urandom_range(0, 3);
				repeat (n) build_type(q, lvl + 1);
				q.push_back(")");
			end
			8, 9: begin
				if (pick == 9) q.push_back("a");
				q.push_back("{");
				q.push_back(pick_basic());
				build_type(q, lvl + 1);
				q.push_back("}");
			end
			default: q.push_back($urandom_range(6) == 0 ? 8'("v") : pick_basic());
		endcase
	endfunction

	task automatic send_random_sig();
		logic [7:0] q [$];
		int n;
		n = $urandom_range(1, 4);
		repeat (n) build_type(q, 0);
		// corrupt some signatures: truncate, overwrite, insert, or pure noise
		if ($urandom_range(99) < 15) begin
			case ($urandom_range(3))
				0: if (q.size() > 1) void'(q.pop_back());
				1: q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
				2: q.insert($urandom_range(q.size()), $urandom_range(1) ? 8'(")") : 8'("}"));
				default: begin
					q.delete();
					repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(255)));
				end
			endcase
		end
		send_seq(q);
	endtask

	initial begin
		logic [7:0] q [$];
		int target;
		sb = new();
		arst_n = 0; in_valid = 0; in_data = '0; out_ready = 0;
		hold_req = 0; hold_left = 0; cycles = 0; words_sent = 0;
		gap_pct = 0; stall_pct = 0;
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: all leaves, containers, unit tuple, pair rules, bad characters.
		send_text("(bynqiuxtdhsogv)");
		send_text("()");
		send_text("a{sv}");
		send_text("m(ai)at");
		send_text("{vy}");
		send_text("{yyy}");
		send_text("}");
		send_text(")");
		send_text("a");
		send_text("{y}");
		send_char(8'h00, 0); send_char(8'h41, 1);
		send_char(8'hFF, 1);
		send_text("a(yt)");
		send_text("(y(q)d)n");
		drain();

		// Deepest legal nesting, then one level too deep.
		q.delete(); repeat (DEPTH_LIMIT) q.push_back("a"); q.push_back("y");
		send_seq(q);
		q.delete(); repeat (DEPTH_LIMIT + 1) q.push_back("a"); q.push_back("y");
		send_seq(q);
		drain();

		// Receiver holds off while the sender keeps offering words.
		@(posedge clk);
		hold_req = 1;
		@(negedge clk);
		q.delete(); repeat (80) q.push_back("y");
		send_seq(q);
		drain();

		// Random phases with different idling mixes.
		for (int p = 0; p < 4; p++) begin
			gap_pct   = (p == 1) ? 65 : (p == 3) ? 9 : 0;
			stall_pct = (p == 2) ? 65 : (p == 3) ? 9 : 0;
			target = words_sent + 300;
			while (words_sent < target) send_random_sig();
		end

		drain();
		if (sb.errors == 0 && sb.want_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire
